@@ src/ars_pkg.sv @@
// Package for the address region splitter: request and piece payload types,
// configuration register codes and table constants. No dependencies.
`timescale 1ns / 1ps

package ars_pkg;

  localparam int TABLE_SLOTS      = 3;
  localparam int NUM_REGIONS_DEF  = 3;
  localparam int ADDR_WIDTH_DEF   = 32;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic [1:0] DEFAULT_REGION = 2'd3;
  localparam logic [7:0] ENABLES_RESET  = 8'hC0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_R0_BASE  = 3'd0,
    CFG_R0_SIZE  = 3'd1,
    CFG_R1_BASE  = 3'd2,
    CFG_R1_SIZE  = 3'd3,
    CFG_R2_BASE  = 3'd4,
    CFG_R2_SIZE  = 3'd5,
    CFG_ENABLES  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] start_address;
    logic [15:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  region_index;
    logic [31:0] piece_address;
    logic [15:0] piece_length;
    logic        permitted;
    logic        last_piece;
  } piece_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
  } region_entry_t;

endpackage

@@ src/ars_regfile.sv @@
// Region table and access enable register of the address region splitter.
// Depends on ars_pkg for register codes and the table entry type.
`timescale 1ns / 1ps

module ars_regfile import ars_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]             rd_slot,
  output region_entry_t          rd_entry,
  output logic [7:0]             enables
);

  logic [31:0] base [TABLE_SLOTS];
  logic [31:0] size [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        base[i] <= '0;
        size[i] <= '0;
      end
      enables <= ENABLES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_R0_BASE: base[0] <= cfg_data;
        CFG_R0_SIZE: size[0] <= cfg_data;
        CFG_R1_BASE: base[1] <= cfg_data;
        CFG_R1_SIZE: size[1] <= cfg_data;
        CFG_R2_BASE: base[2] <= cfg_data;
        CFG_R2_SIZE: size[2] <= cfg_data;
        CFG_ENABLES: enables <= cfg_data[7:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // slot three does not exist; the sequencer never scans past NUM_REGIONS-1
  always_comb begin
    if (rd_slot < 2'(TABLE_SLOTS)) begin
      rd_entry.base = base[rd_slot];
      rd_entry.size = size[rd_slot];
    end else begin
      rd_entry = '0;
    end
  end

endmodule

@@ src/address_region_splitter.sv @@
// Top level of the address region splitter: sequencer, shared adder and
// output register. Depends on ars_pkg and ars_regfile.
`timescale 1ns / 1ps

// Address region splitter.
// A request (req_type, start_address, byte_count) arrives on in_valid /
// in_ready. It is decoded against an ordered table of NUM_REGIONS regions
// written through the cfg_write / cfg_index / cfg_data port; an address no
// region holds falls to the default region 3. Each piece leaves on
// out_valid / out_ready with its region, address, length, permission and a
// last_piece flag. A request with zero byte_count produces no piece.
// One request is worked at a time; in_ready is high only while the
// sequencer is idle. Every piece runs a scan of the regions in order
// (1 to NUM_REGIONS tested, stopping at the first hit), a step to size the
// piece and a step to close it, all on a single shared add/subtract unit.
// A request yields up to four pieces at most.
// The output register holds a finished piece while the receiver stalls;
// the sequencer works ahead on the next piece and waits in its closing
// cycle only if that register is still occupied. After the last piece is
// loaded the block is ready for the next request at once.
// Synchronous reset returns to idle, drops any pending piece and restores
// the region table (all unused) and access enables (default region only).

module address_region_splitter import ars_pkg::*; #(
  parameter int NUM_REGIONS = NUM_REGIONS_DEF,
  parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  req_t                   in_req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output piece_t                 out_piece,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // wide enough for base + size and for the clipped region end
  localparam int EW = ((ADDR_WIDTH > 32) ? ADDR_WIDTH : 32) + 1;
  localparam logic [EW-1:0] ADDR_TOP = EW'(1) << ADDR_WIDTH;
  localparam logic [1:0] LAST_SLOT = 2'(NUM_REGIONS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_CALC = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic                  dir;
  logic [ADDR_WIDTH-1:0] addr;
  logic [15:0]           rem;
  logic [1:0]            scan_idx;
  logic [1:0]            reg_idx;
  logic [EW-1:0]         lim;
  logic [15:0]           len;

  region_entry_t         entry;
  logic [7:0]            enables;

  logic [EW-1:0]         alu_a, alu_b, alu_res;
  logic                  alu_sub;

  logic [ADDR_WIDTH-1:0] base_aw;
  logic                  hit;
  logic                  at_top, ok, last, out_free;

  ars_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_slot   (scan_idx),
    .rd_entry  (entry),
    .enables   (enables)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign base_aw  = ADDR_WIDTH'(entry.base);

  // Shared add/subtract unit: region end while scanning, room left in the
  // region while sizing, next address while closing the piece.
  always_comb begin
    alu_a   = EW'(addr);
    alu_b   = EW'(len);
    alu_sub = 1'b0;
    unique case (state)
      S_SCAN: begin
        alu_a = EW'(base_aw);
        alu_b = EW'(entry.size);
      end
      S_CALC: begin
        alu_a   = lim;
        alu_b   = EW'(addr);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
    alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // unused regions (size zero) never hit
  assign hit = (entry.size != '0) && (addr >= base_aw) && (EW'(addr) < alu_res);

  assign at_top = |alu_res[EW-1:ADDR_WIDTH];
  assign ok     = enables[{reg_idx, dir}];
  assign last   = (reg_idx == DEFAULT_REGION) || (len == rem) || at_top || !ok;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid && in_req.byte_count != '0) state_next = S_SCAN;
      S_SCAN: if (hit || scan_idx == LAST_SLOT) state_next = S_CALC;
      S_CALC: state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = last ? S_IDLE : S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        // capture the request and start the scan at slot zero
        dir      <= in_req.req_type;
        addr     <= ADDR_WIDTH'(in_req.start_address);
        rem      <= in_req.byte_count;
        scan_idx <= '0;
      end
      S_SCAN: begin
        if (hit) begin
          reg_idx <= scan_idx;
          lim     <= (alu_res > ADDR_TOP) ? ADDR_TOP : alu_res;
        end else if (scan_idx == LAST_SLOT) begin
          reg_idx <= DEFAULT_REGION;
        end else begin
          scan_idx <= scan_idx + 2'd1;
        end
      end
      S_CALC: begin
        // default region takes everything left; others stop at the clipped region end or when the request runs out
        if (reg_idx == DEFAULT_REGION || alu_res > EW'(rem)) len <= rem;
        else len <= alu_res[15:0];
      end
      S_FIN: begin
        if (out_free) begin
          out_piece.region_index  <= reg_idx;
          out_piece.piece_address <= 32'(addr);
          out_piece.piece_length  <= len;
          out_piece.permitted     <= ok;
          out_piece.last_piece    <= last;
          addr     <= alu_res[ADDR_WIDTH-1:0];
          rem      <= rem - len;
          scan_idx <= '0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_piece.piece_length != '0)
    else $error("piece with zero length");

  a_blocked_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_piece.permitted |-> out_piece.last_piece)
    else $error("blocked piece not marked last");

  a_default_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_piece.region_index == DEFAULT_REGION |-> out_piece.last_piece)
    else $error("default region piece not marked last");

  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_req.byte_count != '0 |=> state == S_SCAN && scan_idx == '0)
    else $error("accepted request did not start a scan at slot zero");

endmodule
